### hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Command codes, character codes and the command word passed from the
// front end to the back end of the text console engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  localparam logic [7:0] ROW_MAX    = 8'd255;
  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] TAB_MASK   = 8'hF8;

  localparam logic REG_TEXT_ATTR = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic        do_write;
    logic        do_scroll;
    logic        do_clear;
    logic        do_read;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [7:0]  shift;
    logic [10:0] cursor;
    logic [7:0]  row_now;
    logic [7:0]  col_now;
  } tcce_cmd_t;

endpackage

### hdl/tcce_ifs.sv
// ----------------------------------------------------------------------------
// tcce_ifs
// Valid/ready channels of the text console engine: request and response.
// ----------------------------------------------------------------------------
interface tcce_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcce_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attribute;
  logic [10:0] cursor_index;
  logic [7:0]  text_row_now;
  logic [6:0]  text_col_now;

  modport source (output valid, cell_char, cell_attribute, cursor_index, text_row_now,
                  text_col_now, input ready);
  modport sink   (input valid, cell_char, cell_attribute, cursor_index, text_row_now,
                  text_col_now, output ready);
endinterface

### hdl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Accepts request words, tracks the text position and cursor, and turns
// each request into a command word for the back end.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  tcce_req_if.sink          req,
  input  logic [7:0]        text_attribute,
  input  logic              init_busy,
  output tcce_pkg::tcce_cmd_t q_data,
  output logic              q_push,
  input  logic              q_full
);
  import tcce_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [7:0] COLS8    = 8'(COLUMNS);
  localparam logic [7:0] ROWS8    = 8'(ROWS);
  localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);

  logic [1:0]  state;
  logic [1:0]  command_r;
  logic [7:0]  code_r;
  logic [4:0]  rrow_r;
  logic [6:0]  rcol_r;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [10:0] cursor;
  logic        upd_cursor;
  tcce_cmd_t   pend;

  logic [7:0]  row_next;
  logic [7:0]  col_next;
  logic        upd_next;
  tcce_cmd_t   entry;
  logic [7:0]  row_inc;
  logic [7:0]  col_dec;
  logic [7:0]  col_inc;
  logic [7:0]  tab_col;
  logic [7:0]  adv_row;
  logic [7:0]  adv_col;
  logic [7:0]  shift;
  logic [15:0] cur_prod;
  logic [15:0] cur_full;
  logic [10:0] cursor_calc;

  assign req.ready = (state == F_IDLE) && !init_busy;

  always_comb begin
    row_inc = (row < ROW_MAX) ? row + 8'd1 : row;
    col_dec = (col != 8'd0) ? col - 8'd1 : col;
    col_inc = col + 8'd1;
    tab_col = ((col + 8'd7) & TAB_MASK) + 8'd1;
    adv_row = (col_inc >= COLS8) ? row_inc : row;
    adv_col = (col_inc >= COLS8) ? 8'd0 : col_inc;
    shift   = adv_row - LAST_ROW;

    row_next   = row;
    col_next   = col;
    upd_next   = 1'b0;
    entry      = '0;
    entry.attr = text_attribute;

    unique case (command_r)
      CMD_PUT: begin
        priority if (code_r == CH_NEWLINE) begin
          row_next = row_inc;
          col_next = 8'd0;
        end else if (code_r == CH_BACKSPACE) begin
          col_next       = col_dec;
          entry.do_write = row < ROWS8;
          entry.cell_row = row;
          entry.cell_col = col_dec;
          entry.ch       = CH_BLANK;
        end else if (code_r == CH_TAB) begin
          if (tab_col >= COLS8) begin
            row_next = row_inc;
            col_next = 8'd0;
          end else begin
            col_next = tab_col;
          end
        end else begin
          entry.do_write = !code_r[7] && (row < ROWS8);
          entry.cell_row = row;
          entry.cell_col = col;
          entry.ch       = code_r;
          col_next       = adv_col;
          upd_next       = 1'b1;
          if (adv_row >= ROWS8) begin
            entry.do_scroll = shift < ROWS8;
            entry.shift     = shift;
            row_next        = LAST_ROW;
          end else begin
            row_next = adv_row;
          end
        end
      end
      CMD_CLEAR: begin
        entry.do_clear = 1'b1;
        row_next       = 8'd0;
        col_next       = 8'd0;
      end
      CMD_READ: begin
        entry.do_read  = ({3'b000, rrow_r} < ROWS8) && ({1'b0, rcol_r} < COLS8);
        entry.cell_row = {3'b000, rrow_r};
        entry.cell_col = {1'b0, rcol_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cur_prod    = row * COLS8;
    cur_full    = cur_prod + {8'd0, col};
    cursor_calc = cur_full[10:0];
    q_data         = pend;
    q_data.cursor  = upd_cursor ? cursor_calc : cursor;
    q_data.row_now = row;
    q_data.col_now = col;
  end

  assign q_push = (state == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      row    <= 8'd0;
      col    <= 8'd0;
      cursor <= 11'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid && req.ready) begin
            command_r <= req.command;
            code_r    <= req.char_code;
            rrow_r    <= req.read_row;
            rcol_r    <= req.read_col;
            state     <= F_CALC;
          end
        end
        F_CALC: begin
          row        <= row_next;
          col        <= col_next;
          pend       <= entry;
          upd_cursor <= upd_next;
          state      <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            if (upd_cursor) begin
              cursor <= cursor_calc;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### hdl/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// Short FIFO of command words between the front end and the back end.
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tcce_pkg::tcce_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output tcce_pkg::tcce_cmd_t pop_data,
  output logic                valid
);
  import tcce_pkg::*;

  tcce_cmd_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Owns the screen memory: cell writes, scroll copy, clear fill, cell reads,
// the fill after reset, and the response register.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tcce_pkg::tcce_cmd_t q_data,
  output logic                q_pop,
  output logic                init_busy,
  tcce_rsp_if.source          rsp
);
  import tcce_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W:0]   CELLS_X   = (ADDR_W + 1)'(CELLS);
  localparam logic [7:0]        COLS8     = 8'(COLUMNS);

  localparam logic [3:0] B_INIT    = 4'd0;
  localparam logic [3:0] B_IDLE    = 4'd1;
  localparam logic [3:0] B_ADDR    = 4'd2;
  localparam logic [3:0] B_WRITE   = 4'd3;
  localparam logic [3:0] B_SCR_SET = 4'd4;
  localparam logic [3:0] B_SCROLL  = 4'd5;
  localparam logic [3:0] B_CLEAR   = 4'd6;
  localparam logic [3:0] B_READ    = 4'd7;
  localparam logic [3:0] B_DONE    = 4'd8;

  logic [15:0]       mem [CELLS];
  logic [3:0]        state;
  tcce_cmd_t         cmd;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] fill;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] dst;
  logic [ADDR_W:0]   cnt;
  logic              copy_pend;
  logic [15:0]       rd_data;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;
  logic [7:0]        mul_a;
  logic [15:0]       prod;
  logic [15:0]       cell_sum;

  assign init_busy = state == B_INIT;
  assign q_pop     = (state == B_IDLE) && q_valid;

  always_comb begin
    mul_a    = (state == B_SCR_SET) ? cmd.shift : cmd.cell_row;
    prod     = mul_a * COLS8;
    cell_sum = prod + {8'd0, cmd.cell_col};
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = cell_addr;
    wdata  = {cmd.attr, cmd.ch};
    raddr  = cell_addr;
    unique case (state)
      B_INIT: begin
        mem_we = 1'b1;
        waddr  = fill;
        wdata  = {RESET_ATTR, 8'd0};
      end
      B_WRITE: mem_we = 1'b1;
      B_SCROLL: begin
        mem_we = copy_pend;
        waddr  = dst;
        wdata  = rd_data;
        raddr  = src;
      end
      B_CLEAR: begin
        mem_we = 1'b1;
        waddr  = fill;
        wdata  = {cmd.attr, 8'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      fill      <= '0;
      copy_pend <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != B_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        B_INIT: begin
          fill <= fill + 1'b1;
          if (fill == LAST_CELL) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            cmd   <= q_data;
            state <= B_ADDR;
          end
        end
        B_ADDR: begin
          cell_addr <= cell_sum[ADDR_W-1:0];
          fill      <= '0;
          priority if (cmd.do_write) state <= B_WRITE;
          else if (cmd.do_scroll)    state <= B_SCR_SET;
          else if (cmd.do_clear)     state <= B_CLEAR;
          else if (cmd.do_read)      state <= B_READ;
          else                       state <= B_DONE;
        end
        B_WRITE: state <= cmd.do_scroll ? B_SCR_SET : B_DONE;
        B_SCR_SET: begin
          src       <= prod[ADDR_W-1:0];
          cnt       <= CELLS_X - prod[ADDR_W:0];
          dst       <= '0;
          copy_pend <= 1'b0;
          state     <= B_SCROLL;
        end
        B_SCROLL: begin
          if (copy_pend) begin
            dst <= dst + 1'b1;
          end
          if (cnt != '0) begin
            src       <= src + 1'b1;
            cnt       <= cnt - 1'b1;
            copy_pend <= 1'b1;
          end else begin
            copy_pend <= 1'b0;
            if (!copy_pend) begin
              state <= B_DONE;
            end
          end
        end
        B_CLEAR: begin
          fill <= fill + 1'b1;
          if (fill == LAST_CELL) begin
            state <= B_DONE;
          end
        end
        B_READ: state <= B_DONE;
        B_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.cell_char      <= cmd.do_read ? rd_data[7:0] : 8'd0;
            rsp.cell_attribute <= cmd.do_read ? rd_data[15:8] : 8'd0;
            rsp.cursor_index   <= cmd.cursor;
            rsp.text_row_now   <= cmd.row_now;
            rsp.text_col_now   <= cmd.col_now[6:0];
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### hdl/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// Teletype engine for a ROWS x COLUMNS screen of character/attribute cells.
//
// req carries one word per command: put character, clear and home, or read
// one cell. rsp returns one word per request with the read cell (zero for
// other commands), the cursor register and the text row and column.
// The APB port holds the text attribute register at address 0.
//
// A front end takes a word and updates the text position in its calc state,
// then queues a command word; the back end executes it against the screen
// RAM, one cell access per cycle. A put that writes a cell without scrolling,
// or a read, passes a write or read state on its way to done; a put that only
// moves the position goes straight there. The queue lets the front end take
// new words while the back end works. A scroll copies (ROWS - shift) * COLUMNS
// cells and a clear fills ROWS * COLUMNS cells, one cell a cycle; a clear is
// the worst case for one word. After reset the back end fills all ROWS *
// COLUMNS RAM cells; req.ready stays low until that pass is done. A stalled rsp
// holds its word; the back end holds the next, the queue 4 more words and the
// front end one, and then req.ready stays low.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  tcce_req_if.sink    req,
  tcce_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcce_pkg::*;

  logic [7:0] text_attribute;
  tcce_cmd_t  push_data;
  tcce_cmd_t  pop_data;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  logic       init_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, text_attribute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR)) begin
      text_attribute <= pwdata[7:0];
    end
  end

  tcce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .text_attribute (text_attribute),
    .init_busy      (init_busy),
    .q_data         (push_data),
    .q_push         (q_push),
    .q_full         (q_full)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .valid     (q_valid)
  );

  tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !req.ready)
    else $error("request accepted during RAM fill");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

endmodule
